// File: hdl/rmip_pkg.sv
// ----------------------------------------------------------------------------
// rmip_pkg
// shared widths, item codes and result codes of the matching index picker
// ----------------------------------------------------------------------------
package rmip_pkg;

  localparam int KIND_W      = 2;
  localparam int VALUE_W     = 32;
  localparam int RND_W       = 31;
  localparam int STATUS_W    = 3;
  localparam int INDEX_W     = 6;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 8;

  localparam int DEF_TABLE_DEPTH = 64;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;

  // input item kinds
  localparam kind_t KIND_LOAD  = 2'd0;
  localparam kind_t KIND_PICK  = 2'd1;
  localparam kind_t KIND_CLEAR = 2'd2;

  // result status codes
  localparam status_t ST_LOADED  = 3'd0;
  localparam status_t ST_FULL    = 3'd1;
  localparam status_t ST_PICKED  = 3'd2;
  localparam status_t ST_ABSENT  = 3'd3;
  localparam status_t ST_CLEARED = 3'd4;

endpackage

// File: hdl/random_matching_index_pick.sv
// ----------------------------------------------------------------------------
// random_matching_index_pick
// value table with random choice among the entries that match a target
// ----------------------------------------------------------------------------
// One input word on the s_axis channel gives one result word on m_axis.
// A load word appends its value to the table (status full once the table
// holds TABLE_DEPTH entries), a clear word empties it, a pick word names a
// target and a random number. For a pick the table is swept once through its
// read port to count matches, the random number is reduced modulo that count
// in a bit-serial remainder unit, and the table is swept again to find the
// chosen match. The two sweeps through the single read port and the remainder
// unit set how long a pick takes; a pick with no match skips the remainder
// unit and the second sweep. s_axis_tready is high only while the block is
// idle, one word at a time. A finished result sits in the output register;
// while the receiver stalls the register holds its result, and the block can
// take a new word but holds its next result until the register is free.
// Reset empties the table and drops any pending result; table contents are
// left as they are, only the count is cleared.
// ----------------------------------------------------------------------------
module random_matching_index_pick #(
  parameter int TABLE_DEPTH = rmip_pkg::DEF_TABLE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // value [31:0], random_value [62:32], zero pad [63]
  input  logic [rmip_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // kind [1:0]
  input  logic [rmip_pkg::KIND_W-1:0]     s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // index [5:0], zero pad [7:6]
  output logic [rmip_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // status [2:0]
  output logic [rmip_pkg::STATUS_W-1:0]   m_axis_tuser
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN1 = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_SCAN2 = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]                      state;
  logic [CW-1:0]                   entry_count;
  logic [rmip_pkg::VALUE_W-1:0]    target;
  logic [rmip_pkg::RND_W-1:0]      rnd;
  logic [CW-1:0]                   scan_ptr;
  logic                            cmp_valid;
  logic [CW-1:0]                   cmp_pos;
  logic [CW-1:0]                   match_count;
  logic [CW-1:0]                   seen;
  logic [CW-1:0]                   pick_r;
  logic                            mod_start;
  logic                            mod_done;
  logic [CW-1:0]                   mod_rem;
  rmip_pkg::status_t               res_status;
  logic [rmip_pkg::INDEX_W-1:0]    res_index;

  logic                            accept;
  logic                            table_full;
  logic                            issue;
  logic                            scan_done;
  logic                            out_load;
  logic                            match;
  logic                            ram_we;
  logic [AW-1:0]                   ram_raddr;
  logic [rmip_pkg::VALUE_W-1:0]    ram_rdata;
  rmip_pkg::kind_t                 in_kind;
  logic [rmip_pkg::VALUE_W-1:0]    in_value;

  // input handshake and table access
  always_comb begin
    s_axis_tready = (state == S_IDLE);
    accept        = s_axis_tvalid && s_axis_tready;
    in_kind       = s_axis_tuser;
    in_value      = s_axis_tdata[rmip_pkg::VALUE_W-1:0];
    table_full    = (entry_count == CW'(TABLE_DEPTH));
    ram_we        = accept && (in_kind == rmip_pkg::KIND_LOAD) && !table_full;
    issue         = ((state == S_SCAN1) || (state == S_SCAN2)) && (scan_ptr < entry_count);
    scan_done     = !issue && !cmp_valid;
    out_load      = (state == S_RESP) && (!m_axis_tvalid || m_axis_tready);
    ram_raddr     = scan_ptr[AW-1:0];
    match         = cmp_valid && (ram_rdata == target);
  end

  rmip_ram #(
    .WIDTH(rmip_pkg::VALUE_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(entry_count[AW-1:0]),
    .wdata(in_value),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  rmip_mod #(
    .CW(CW)
  ) u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (mod_start),
    .dividend(rnd),
    .divisor (match_count),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      entry_count   <= '0;
      cmp_valid     <= 1'b0;
      mod_start     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // remainder unit starts once the first sweep has found matches
      mod_start <= (state == S_SCAN1) && scan_done && (match_count != '0);
      // output register valid
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          cmp_valid <= 1'b0;
          if (accept) begin
            target      <= in_value;
            rnd         <= s_axis_tdata[rmip_pkg::VALUE_W +: rmip_pkg::RND_W];
            res_index   <= '0;
            scan_ptr    <= '0;
            match_count <= '0;
            case (in_kind)
              rmip_pkg::KIND_LOAD: begin
                state <= S_RESP;
                if (table_full) begin
                  res_status <= rmip_pkg::ST_FULL;
                end else begin
                  entry_count <= entry_count + CW'(1);
                  res_status  <= rmip_pkg::ST_LOADED;
                end
              end
              rmip_pkg::KIND_PICK: begin
                state <= S_SCAN1;
              end
              rmip_pkg::KIND_CLEAR: begin
                state       <= S_RESP;
                entry_count <= '0;
                res_status  <= rmip_pkg::ST_CLEARED;
              end
              default: begin
                state      <= S_RESP;
                res_status <= rmip_pkg::ST_ABSENT;
              end
            endcase
          end
        end
        // first sweep counts matches
        S_SCAN1: begin
          cmp_valid <= issue;
          cmp_pos   <= scan_ptr;
          if (issue) begin
            scan_ptr <= scan_ptr + CW'(1);
          end
          if (match) begin
            match_count <= match_count + CW'(1);
          end
          if (scan_done) begin
            if (match_count == '0) begin
              res_status <= rmip_pkg::ST_ABSENT;
              state      <= S_RESP;
            end else begin
              state <= S_MOD;
            end
          end
        end
        // wait for remainder of random number by match count
        S_MOD: begin
          cmp_valid <= 1'b0;
          if (mod_done) begin
            pick_r   <= mod_rem;
            scan_ptr <= '0;
            seen     <= '0;
            state    <= S_SCAN2;
          end
        end
        // second sweep finds the chosen match
        S_SCAN2: begin
          cmp_valid <= issue;
          cmp_pos   <= scan_ptr;
          if (issue) begin
            scan_ptr <= scan_ptr + CW'(1);
          end
          if (match) begin
            if (seen == pick_r) begin
              res_status <= rmip_pkg::ST_PICKED;
              res_index  <= rmip_pkg::INDEX_W'(cmp_pos);
              state      <= S_RESP;
            end else begin
              seen <= seen + CW'(1);
            end
          end
        end
        // hand the result to the output register once it is free
        S_RESP: begin
          cmp_valid <= 1'b0;
          if (out_load) begin
            m_axis_tuser <= res_status;
            m_axis_tdata <= rmip_pkg::OUT_TDATA_W'(res_index);
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/rmip_ram.sv
// ----------------------------------------------------------------------------
// rmip_ram
// generic simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module rmip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/rmip_mod.sv
// ----------------------------------------------------------------------------
// rmip_mod
// iterative restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module rmip_mod #(
  parameter int CW = 7
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [rmip_pkg::RND_W-1:0] dividend,
  input  logic [CW-1:0]            divisor,
  output logic                     done,
  output logic [CW-1:0]            rem
);

  localparam int SW = $clog2(rmip_pkg::RND_W);

  logic                       busy;
  logic [SW-1:0]              step;
  logic [rmip_pkg::RND_W-1:0] dvd;
  logic [CW:0]                trial;
  logic                       ge;
  logic [CW-1:0]              rem_next;

  // shift in next dividend bit and subtract where it fits
  always_comb begin
    trial    = {rem, dvd[rmip_pkg::RND_W-1]};
    ge       = (trial >= {1'b0, divisor});
    rem_next = ge ? CW'(trial - {1'b0, divisor}) : CW'(trial);
  end

  // sequencing of the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        rem  <= '0;
        dvd  <= dividend;
      end else if (busy) begin
        rem  <= rem_next;
        dvd  <= {dvd[rmip_pkg::RND_W-2:0], 1'b0};
        step <= step + SW'(1);
        if (step == SW'(rmip_pkg::RND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: hdl/rmip_checker.sv
// ----------------------------------------------------------------------------
// rmip_checker
// port-level checks of the matching index picker, bound to the top level
// ----------------------------------------------------------------------------
module rmip_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [rmip_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [rmip_pkg::STATUS_W-1:0]    m_axis_tuser
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // status is always a defined code
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser <= rmip_pkg::ST_CLEARED))
    else $error("undefined status code");

  // index is zero unless a match was picked
  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != rmip_pkg::ST_PICKED) |-> (m_axis_tdata == '0))
    else $error("non-zero index without a pick");

  // one word at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("new word taken while previous word in progress");

endmodule

bind random_matching_index_pick rmip_checker u_rmip_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
